>>> sv/sem_pkg.sv
package sem_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd480;

    localparam int ROW_W = 11;
    localparam logic [ROW_W-1:0] HEIGHT_MIN = 11'd3;
    localparam logic [ROW_W-1:0] HEIGHT_MAX = 11'd1024;
    localparam int WIDTH_MIN = 3;

    localparam int PIX_W = 8;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    localparam int OUT_FIFO_DEPTH = 4;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t value;
        logic   end_of_row;
        logic   end_of_frame;
    } result_word_t;

    function automatic pixel_t clamp_byte(input logic signed [10:0] v);
        pixel_t res;
        if (v < 0)
        begin
            res = '0;
        end
        else if (v > 11'sd255)
        begin
            res = PIX_MAX;
        end
        else
        begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage

>>> sv/sem_ram.sv
module sem_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/sobel_edge_magnitude.sv
// Streaming 3x3 Sobel edge magnitude over an 8-bit grey frame in raster order.
// Pixels enter on the pixel channel (pixel_valid/pixel_ready); each output word
// leaves on the result channel (result_valid/result_ready) with pixel_out,
// end_of_row and end_of_frame. After each frame the host sends image_width+1
// padding words whose values are ignored; they flush the last row.
// The first image_width+1 words of a frame give no result; every later word,
// padding included, gives exactly one. A result is registered in stage 1 and
// stage 2 and written to the output queue before the result channel offers it.
// One word is accepted per cycle while pixel_ready is high. The two previous
// rows live in one line memory with both rows side by side, read and written
// back at the same column for each word; a one-entry bypass covers a read of
// the column just written. A four-word output queue takes results while the
// receiver stalls, and pixel_ready drops only when that queue and the two
// internal stages could otherwise overflow.
// Reset sets image_width to 640 and image_height to 480, clears the window and
// the frame position and empties the queue. The line memory is not cleared.
// image_width and image_height are written via write_enable, register_index and
// write_data; the user must write them while the block is idle (unchecked).
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             write_enable,
    input  logic [sem_pkg::CFG_INDEX_W-1:0]  register_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]   write_data,
    input  logic [7:0]                       pixel_in,
    input  logic                             pixel_valid,
    output logic                             pixel_ready,
    output logic [7:0]                       pixel_out,
    output logic                             end_of_row,
    output logic                             end_of_frame,
    output logic                             result_valid,
    input  logic                             result_ready
);

    import sem_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int QAW = $clog2(OUT_FIFO_DEPTH);

    logic [CFG_DATA_W-1:0] image_width_reg;
    logic [CFG_DATA_W-1:0] image_height_reg;

    logic [CW:0]      width_used;
    logic [ROW_W-1:0] height_used;

    logic [CW-1:0]    col_reg;
    logic [CW-1:0]    col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic [CW-1:0]    col_eff;
    logic             accept;
    logic             is_last;
    pixel_t           px_in;
    logic             has_out;
    logic             grad_en;

    logic             s1_valid_reg;
    logic [CW-1:0]    s1_addr_reg;
    pixel_t           s1_px_reg;
    logic             s1_out_reg;
    logic             s1_grad_reg;
    logic             s1_eor_reg;
    logic             s1_eof_reg;
    logic             fwd_hit_reg;
    logic [15:0]      fwd_data_reg;

    logic [15:0]      ram_rdata;
    logic [15:0]      row_pair;
    logic [15:0]      ram_wdata;
    pixel_t           up2;
    pixel_t           up1;

    pixel_t           win_reg [9];

    logic             s2_valid_reg;
    logic             s2_grad_reg;
    logic             s2_eor_reg;
    logic             s2_eof_reg;

    logic [9:0]       sum_left;
    logic [9:0]       sum_right;
    logic [9:0]       sum_top;
    logic [9:0]       sum_bottom;
    logic [8:0]       mag_sum;
    pixel_t           mag;
    result_word_t     s2_word;

    result_word_t     fifo_reg [OUT_FIFO_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     count_reg;
    logic             fifo_pop;
    logic [QAW+1:0]   credit_used;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (write_enable)
        begin
            unique case (register_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= write_data;
                REG_IMAGE_HEIGHT: image_height_reg <= write_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (image_width_reg < CFG_DATA_W'(WIDTH_MIN))
        begin
            width_used = (CW+1)'(WIDTH_MIN);
        end
        else if (int'(image_width_reg) > MAX_WIDTH)
        begin
            width_used = (CW+1)'(MAX_WIDTH);
        end
        else
        begin
            width_used = (CW+1)'(image_width_reg);
        end

        if (image_height_reg < HEIGHT_MIN)
        begin
            height_used = HEIGHT_MIN;
        end
        else if (image_height_reg > HEIGHT_MAX)
        begin
            height_used = HEIGHT_MAX;
        end
        else
        begin
            height_used = image_height_reg;
        end
    end

    always_comb
    begin
        if ({1'b0, col_reg} >= width_used)
        begin
            col_eff = CW'(width_used - 1'b1);
        end
        else
        begin
            col_eff = col_reg;
        end

        is_last = row_reg >= height_used + 1'b1;
        px_in   = (row_reg < height_used) ? pixel_in : '0;
        has_out = (row_reg >= ROW_W'(2)) || (row_reg == ROW_W'(1) && col_eff != '0);
        grad_en = (col_eff >= CW'(2)) && (row_reg >= ROW_W'(2))
                  && (row_reg <= height_used - 1'b1);

        if (is_last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if ({1'b0, col_eff} >= width_used - 1'b1)
        begin
            col_next = '0;
            row_next = row_reg + 1'b1;
        end
        else
        begin
            col_next = col_eff + 1'b1;
            row_next = row_reg;
        end
    end

    assign credit_used = (QAW+2)'(count_reg) + (QAW+2)'(s1_valid_reg)
                       + (QAW+2)'(s2_valid_reg);
    assign pixel_ready = credit_used < (QAW+2)'(OUT_FIFO_DEPTH);
    assign accept      = pixel_valid && pixel_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                fwd_hit_reg <= s1_valid_reg && (s1_addr_reg == col_eff);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg  <= col_eff;
            s1_px_reg    <= px_in;
            s1_out_reg   <= has_out;
            s1_grad_reg  <= grad_en;
            s1_eor_reg   <= (col_eff == '0);
            s1_eof_reg   <= is_last;
            fwd_data_reg <= ram_wdata;
        end
    end

    // Upper byte holds the older row, lower byte the newer row.
    assign row_pair  = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign up2       = row_pair[15:8];
    assign up1       = row_pair[7:0];
    assign ram_wdata = {up1, s1_px_reg};

    sem_ram #(
        .DATA_W (16),
        .DEPTH  (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (col_eff),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg && s1_out_reg;
            if (s1_valid_reg)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i*3]     <= win_reg[i*3 + 1];
                    win_reg[i*3 + 1] <= win_reg[i*3 + 2];
                end
                win_reg[2] <= up2;
                win_reg[5] <= up1;
                win_reg[8] <= s1_px_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_grad_reg <= s1_grad_reg;
            s2_eor_reg  <= s1_eor_reg;
            s2_eof_reg  <= s1_eof_reg;
        end
    end

    always_comb
    begin
        sum_left   = {2'b00, win_reg[0]} + {1'b0, win_reg[3], 1'b0} + {2'b00, win_reg[6]};
        sum_right  = {2'b00, win_reg[2]} + {1'b0, win_reg[5], 1'b0} + {2'b00, win_reg[8]};
        sum_top    = {2'b00, win_reg[0]} + {1'b0, win_reg[1], 1'b0} + {2'b00, win_reg[2]};
        sum_bottom = {2'b00, win_reg[6]} + {1'b0, win_reg[7], 1'b0} + {2'b00, win_reg[8]};
        mag_sum = {1'b0, clamp_byte($signed({1'b0, sum_right}) - $signed({1'b0, sum_left}))}
                + {1'b0, clamp_byte($signed({1'b0, sum_bottom}) - $signed({1'b0, sum_top}))};
        mag = mag_sum[8] ? PIX_MAX : mag_sum[7:0];

        s2_word.value        = s2_grad_reg ? mag : win_reg[4];
        s2_word.end_of_row   = s2_eor_reg;
        s2_word.end_of_frame = s2_eof_reg;
    end

    assign fifo_pop = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (s2_valid_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (fifo_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QAW+1)'(s2_valid_reg) - (QAW+1)'(fifo_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            fifo_reg[wr_ptr_reg] <= s2_word;
        end
    end

    assign result_valid = count_reg != '0;
    assign pixel_out    = fifo_reg[rd_ptr_reg].value;
    assign end_of_row   = fifo_reg[rd_ptr_reg].end_of_row;
    assign end_of_frame = fifo_reg[rd_ptr_reg].end_of_frame;

endmodule
